// File: hdl/mcm_pkg.sv
// Shared types, constants and helpers for the Clause 45 MDIO frame master.
package mcm_pkg;

  localparam int PREAMBLE_BITS = 32;
  localparam int TOTAL_BITS    = PREAMBLE_BITS + 32;
  localparam int POS_W         = $clog2(TOTAL_BITS);

  // Input opcodes.
  localparam logic [2:0] OP_ADDR  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_PRIA  = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // Frame kinds as held by the engine.
  localparam logic [1:0] KIND_ADDR  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_PRIA  = 2'd3;

  localparam logic [15:0] WORD_MASK = 16'hFFFF;

  typedef enum logic [1:0] {
    IK_NONE,
    IK_CMD,
    IK_TICK
  } item_kind_t;

  // A classified word as it travels from the front end to the engine.
  typedef struct packed {
    item_kind_t  kind;
    logic [1:0]  frame_kind;
    logic [4:0]  port_addr;
    logic [4:0]  dev_addr;
    logic [15:0] word_value;
    logic        mdio_sample;
  } item_t;

  function automatic logic kind_is_read(input logic [1:0] k);
    return (k == KIND_READ) || (k == KIND_PRIA);
  endfunction

  // Two-bit opcode sent on the wire for a frame kind.
  function automatic logic [1:0] wire_opcode(input logic [1:0] k);
    logic [1:0] w;
    unique case (k)
      KIND_ADDR:  w = 2'b00;
      KIND_WRITE: w = 2'b01;
      KIND_READ:  w = 2'b11;
      default:    w = 2'b10;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/mcm_front.sv
// Front end: decodes the input opcode and builds the classified word.
module mcm_front (
  input  logic             in_valid,
  input  logic [2:0]       in_opcode,
  input  logic [4:0]       in_port_addr,
  input  logic [4:0]       in_dev_addr,
  input  logic [15:0]      in_word_value,
  input  logic             in_mdio_sample,
  input  logic             q_full,
  output logic             in_ready,
  output logic             push,
  output mcm_pkg::item_t   push_item
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.port_addr   = in_port_addr;
    push_item.dev_addr    = in_dev_addr;
    push_item.mdio_sample = in_mdio_sample;
    push_item.frame_kind  = in_opcode[1:0];
    push_item.word_value  = in_word_value;
    unique case (in_opcode)
      mcm_pkg::OP_ADDR, mcm_pkg::OP_WRITE: begin
        push_item.kind = mcm_pkg::IK_CMD;
      end
      mcm_pkg::OP_READ, mcm_pkg::OP_PRIA: begin
        // Read frames carry no word; the engine holds all ones instead.
        push_item.kind       = mcm_pkg::IK_CMD;
        push_item.word_value = mcm_pkg::WORD_MASK;
      end
      mcm_pkg::OP_TICK: begin
        push_item.kind = mcm_pkg::IK_TICK;
      end
      default: begin
        push_item.kind = mcm_pkg::IK_NONE;
      end
    endcase
  end

endmodule

// File: hdl/mcm_queue.sv
// Two-entry queue of classified words between the front end and the engine.
module mcm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mcm_pkg::item_t   push_item,
  input  logic             pop,
  output logic             q_valid,
  output logic             q_full,
  output mcm_pkg::item_t   head_item
);

  mcm_pkg::item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_valid   = (count_r != 2'd0);
  assign q_full    = (count_r == 2'd2);
  assign head_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/mcm_back.sv
// Frame engine: bit counter, held frame fields, read shifter and output register.
module mcm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  mcm_pkg::item_t   head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_accepted,
  output logic             out_line_value,
  output logic             out_line_drive,
  output logic             out_busy_res,
  output logic             out_frame_done,
  output logic [15:0]      out_read_data,
  output logic             out_read_ok
);

  localparam int PW = mcm_pkg::POS_W;
  localparam logic [PW-1:0] P_SYNC = PW'(mcm_pkg::PREAMBLE_BITS);
  localparam logic [PW-1:0] P_OP   = PW'(mcm_pkg::PREAMBLE_BITS + 2);
  localparam logic [PW-1:0] P_PORT = PW'(mcm_pkg::PREAMBLE_BITS + 4);
  localparam logic [PW-1:0] P_DEV  = PW'(mcm_pkg::PREAMBLE_BITS + 9);
  localparam logic [PW-1:0] P_TA   = PW'(mcm_pkg::PREAMBLE_BITS + 14);
  localparam logic [PW-1:0] P_DATA = PW'(mcm_pkg::PREAMBLE_BITS + 16);
  localparam logic [PW-1:0] P_LAST = PW'(mcm_pkg::TOTAL_BITS - 1);

  logic          active_r, active_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [4:0]    port_r, port_nxt;
  logic [4:0]    dev_r, dev_nxt;
  logic [15:0]   word_r, word_nxt;
  logic [15:0]   shift_r, shift_nxt;
  logic          turn_r, turn_nxt;

  logic          out_valid_r;
  logic          acc_r, val_r, drv_r, done_r;
  logic          acc_nxt, val_nxt, drv_nxt, done_nxt;

  logic          rd;
  logic [1:0]    wop;
  logic [PW-1:0] op_off, port_off, dev_off, data_off;

  assign pop = q_valid && (!out_valid_r || out_ready);

  assign rd       = mcm_pkg::kind_is_read(kind_r);
  assign wop      = mcm_pkg::wire_opcode(kind_r);
  // Offsets count down from the field's MSB, as the bits go out MSB first.
  assign op_off   = P_OP + PW'(1) - pos_r;
  assign port_off = P_PORT + PW'(4) - pos_r;
  assign dev_off  = P_DEV + PW'(4) - pos_r;
  assign data_off = P_LAST - pos_r;

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    kind_nxt   = kind_r;
    port_nxt   = port_r;
    dev_nxt    = dev_r;
    word_nxt   = word_r;
    shift_nxt  = shift_r;
    turn_nxt   = turn_r;
    acc_nxt    = 1'b0;
    val_nxt    = 1'b1;
    drv_nxt    = 1'b0;
    done_nxt   = 1'b0;
    case (head_item.kind)
      mcm_pkg::IK_CMD: begin
        if (!active_r) begin
          acc_nxt    = 1'b1;
          active_nxt = 1'b1;
          pos_nxt    = '0;
          kind_nxt   = head_item.frame_kind;
          port_nxt   = head_item.port_addr;
          dev_nxt    = head_item.dev_addr;
          word_nxt   = head_item.word_value;
        end
      end
      mcm_pkg::IK_TICK: begin
        if (active_r) begin
          drv_nxt = 1'b1;
          if (pos_r < P_SYNC) begin
            val_nxt = 1'b1;
          end else if (pos_r < P_OP) begin
            val_nxt = 1'b0;
          end else if (pos_r < P_PORT) begin
            val_nxt = wop[op_off[0]];
          end else if (pos_r < P_DEV) begin
            val_nxt = port_r[port_off[2:0]];
          end else if (pos_r < P_TA) begin
            val_nxt = dev_r[dev_off[2:0]];
          end else if (pos_r == P_TA) begin
            val_nxt = 1'b1;
          end else if (pos_r == P_TA + PW'(1)) begin
            if (rd) begin
              drv_nxt  = 1'b0;
              val_nxt  = 1'b1;
              turn_nxt = head_item.mdio_sample;
            end else begin
              val_nxt = 1'b0;
            end
          end else begin
            if (rd) begin
              drv_nxt   = 1'b0;
              val_nxt   = 1'b1;
              shift_nxt = {shift_r[14:0], head_item.mdio_sample};
            end else begin
              val_nxt = word_r[data_off[3:0]];
            end
          end
          if (pos_r == P_LAST) begin
            done_nxt   = 1'b1;
            active_nxt = 1'b0;
            pos_nxt    = '0;
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      kind_r      <= mcm_pkg::KIND_ADDR;
      port_r      <= '0;
      dev_r       <= '0;
      word_r      <= '0;
      shift_r     <= '0;
      turn_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        active_r <= active_nxt;
        pos_r    <= pos_nxt;
        kind_r   <= kind_nxt;
        port_r   <= port_nxt;
        dev_r    <= dev_nxt;
        word_r   <= word_nxt;
        shift_r  <= shift_nxt;
        turn_r   <= turn_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the flag outputs of the state are taken after the update.
  always_ff @(posedge clk) begin
    if (pop) begin
      acc_r  <= acc_nxt;
      val_r  <= val_nxt;
      drv_r  <= drv_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = acc_r;
  assign out_line_value = val_r;
  assign out_line_drive = drv_r;
  assign out_frame_done = done_r;
  assign out_busy_res   = active_r;
  assign out_read_data  = shift_r;
  assign out_read_ok    = !turn_r;

endmodule

// File: hdl/mdio_clause45_frame_master.sv
// Top level of the Clause 45 MDIO frame master.
// Each input word is either a frame command (address, write, read or
// post-read-increment read) or a tick that stands for one MDC period, and
// each produces exactly one result word. The block takes one word per clock
// cycle while its queue is not full. A word first lands in a two-entry
// queue, and the frame engine, whose bit counter and read shifter finish one
// bus bit per tick word, then works it into an output register, from which
// its result is offered. The queue lets up to two words be taken while a
// finished result waits on out_ready.
// A frame is 32 preamble ones, start, opcode, port, device, turnaround and
// 16 data bits, MSB first; commands that arrive mid-frame are reported as
// not accepted and leave the frame untouched.
module mdio_clause45_frame_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [4:0]  in_port_addr,
  input  logic [4:0]  in_dev_addr,
  input  logic [15:0] in_word_value,
  input  logic        in_mdio_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_line_value,
  output logic        out_line_drive,
  output logic        out_busy_res,
  output logic        out_frame_done,
  output logic [15:0] out_read_data,
  output logic        out_read_ok
);

  logic           q_full;
  logic           q_valid;
  logic           push;
  logic           pop;
  mcm_pkg::item_t push_item;
  mcm_pkg::item_t head_item;

  mcm_front u_front (
    .in_valid       (in_valid),
    .in_opcode      (in_opcode),
    .in_port_addr   (in_port_addr),
    .in_dev_addr    (in_dev_addr),
    .in_word_value  (in_word_value),
    .in_mdio_sample (in_mdio_sample),
    .q_full         (q_full),
    .in_ready       (in_ready),
    .push           (push),
    .push_item      (push_item)
  );

  mcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head_item (head_item)
  );

  mcm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_line_value (out_line_value),
    .out_line_drive (out_line_drive),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done),
    .out_read_data  (out_read_data),
    .out_read_ok    (out_read_ok)
  );

endmodule

// File: hdl/mcm_checker.sv
// Port-level checks on the MDIO frame master, bound to the top level.
module mcm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_accepted,
  input  logic        out_line_value,
  input  logic        out_line_drive,
  input  logic        out_busy_res,
  input  logic        out_frame_done
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A started frame is in progress straight after its command.
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_busy_res && !out_line_drive && !out_frame_done)
    else $error("accepted command without a frame in progress");

  // The last bit ends the frame; a read has the line released by then.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res)
    else $error("frame end reported with bus still busy");

  // A released line always reads as high.
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_drive |-> out_line_value)
    else $error("released line reported low");

endmodule

bind mdio_clause45_frame_master mcm_checker u_mcm_checker (.*);
